### rtl/cdq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_pkg: shared definitions for the circular deque engine
// Sizes, operation and status codes, ring request types and the index wrap.
// ----------------------------------------------------------------------------
package cdq_pkg;

    // Ring size and derived widths.
    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Field widths.
    localparam int DATA_W = 32;
    localparam int POS_W  = 4;
    localparam int ACT_W  = 3;
    localparam int STAT_W = 2;

    // Stream payload widths, padded to whole bytes.
    localparam int S_TDATA_W = ((DATA_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((DATA_W + POS_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - DATA_W - POS_W;

    // Operation codes carried with each request.
    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_POP_FRONT  = 3'd1,
        ACT_PUSH_BACK  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_TRAVERSE   = 3'd4,
        ACT_SEARCH     = 3'd5
    } action_t;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    // Write and read requests to the ring storage.
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        logic [DATA_W-1:0] data;
    } wr_req_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } rd_req_t;

    // Ring index of the entry at offset off from idx; the sum stays below
    // twice the capacity, so one compare and subtract wraps it.
    function automatic logic [IDX_W-1:0] wrap_add(
        input logic [IDX_W-1:0] idx,
        input logic [CNT_W-1:0] off
    );
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(idx) + {1'b0, off};
        if (sum >= (CNT_W+1)'(CAPACITY))
        begin
            sum = sum - (CNT_W+1)'(CAPACITY);
        end
        return IDX_W'(sum);
    endfunction

endpackage
`default_nettype wire

### rtl/cdq_ring.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_ring: ring storage of the deque
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cdq_ring (
    input  wire logic                      clk,
    input  wire cdq_pkg::wr_req_t          wr,
    input  wire cdq_pkg::rd_req_t          rd,
    output logic [cdq_pkg::DATA_W-1:0]     rd_data
);

    logic [cdq_pkg::DATA_W-1:0] mem [cdq_pkg::CAPACITY];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Read port; the data register holds until the next read.
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data <= mem[rd.addr];
        end
    end

endmodule
`default_nettype wire

### rtl/circular_deque_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// circular_deque_engine: bounded double-ended queue of signed 32-bit values
// Push and pop at either end, traverse from front to back, and key search.
// ----------------------------------------------------------------------------
// The engine takes one request at a time and is ready only while idle. A push
// or pop is accepted, then executed with its result loaded. A traverse or
// search is accepted and executed, then visits the stored entries in turn,
// because the entries are read one at a time through the single read port of
// the ring storage. Each result sits in an output register, so a stalled
// result holds the request until the receiver takes it. Unknown operation
// codes are dropped without a result.
// ----------------------------------------------------------------------------
module circular_deque_engine (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [cdq_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // [31:0] value
    input  wire logic [cdq_pkg::ACT_W-1:0]       s_axis_tuser,  // [2:0] action
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [cdq_pkg::M_TDATA_W-1:0]        m_axis_tdata,  // [31:0] item,
                                                                // [35:32] position
    output logic [cdq_pkg::STAT_W-1:0]           m_axis_tuser,  // [1:0] status
    output logic                                 m_axis_tlast
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_EVAL = 3'b100
    } state_t;

    state_t                          state_reg, state_next;
    cdq_pkg::action_t                action_reg, action_next;
    logic [cdq_pkg::DATA_W-1:0]      value_reg, value_next;
    logic [cdq_pkg::IDX_W-1:0]       front_reg, front_next;
    logic [cdq_pkg::CNT_W-1:0]       occ_reg, occ_next;
    logic [cdq_pkg::CNT_W-1:0]       scan_reg, scan_next;

    logic                            out_valid_reg, out_valid_next;
    cdq_pkg::status_t                out_status_reg, out_status_next;
    logic [cdq_pkg::DATA_W-1:0]      out_item_reg, out_item_next;
    logic [cdq_pkg::POS_W-1:0]       out_pos_reg, out_pos_next;
    logic                            out_last_reg, out_last_next;

    cdq_pkg::wr_req_t                wr;
    cdq_pkg::rd_req_t                rd;
    logic [cdq_pkg::DATA_W-1:0]      rd_data;

    logic                            slot_free;
    logic                            is_full;
    logic                            is_empty;
    logic                            scan_last;
    logic [cdq_pkg::CNT_W-1:0]       scan_inc;

    cdq_ring u_ring (
        .clk     (clk),
        .wr      (wr),
        .rd      (rd),
        .rd_data (rd_data)
    );

    // Status of the ring and of the output register.
    assign slot_free = !out_valid_reg || m_axis_tready;
    assign is_full   = (occ_reg == cdq_pkg::CNT_W'(cdq_pkg::CAPACITY));
    assign is_empty  = (occ_reg == '0);
    assign scan_inc  = scan_reg + cdq_pkg::CNT_W'(1);
    assign scan_last = (scan_inc == occ_reg);

    // Sequencer: accept, execute, then walk the ring for traverse and search.
    always_comb
    begin
        state_next      = state_reg;
        action_next     = action_reg;
        value_next      = value_reg;
        front_next      = front_reg;
        occ_next        = occ_reg;
        scan_next       = scan_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_status_next = out_status_reg;
        out_item_next   = out_item_reg;
        out_pos_next    = out_pos_reg;
        out_last_next   = out_last_reg;
        wr              = '0;
        rd              = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    action_next = cdq_pkg::action_t'(s_axis_tuser);
                    value_next  = s_axis_tdata[cdq_pkg::DATA_W-1:0];
                    state_next  = S_EXEC;
                end
            end

            S_EXEC:
            begin
                case (action_reg)
                    cdq_pkg::ACT_PUSH_FRONT,
                    cdq_pkg::ACT_PUSH_BACK,
                    cdq_pkg::ACT_POP_FRONT,
                    cdq_pkg::ACT_POP_BACK:
                    begin
                        if (slot_free)
                        begin
                            out_valid_next  = 1'b1;
                            out_status_next = cdq_pkg::ST_OK;
                            out_item_next   = '0;
                            out_pos_next    = '0;
                            out_last_next   = 1'b1;
                            state_next      = S_IDLE;
                            if (action_reg == cdq_pkg::ACT_PUSH_FRONT ||
                                action_reg == cdq_pkg::ACT_PUSH_BACK)
                            begin
                                if (is_full)
                                begin
                                    out_status_next = cdq_pkg::ST_OVERFLOW;
                                end
                                else
                                begin
                                    wr.en    = 1'b1;
                                    wr.data  = value_reg;
                                    occ_next = occ_reg + cdq_pkg::CNT_W'(1);
                                    if (action_reg == cdq_pkg::ACT_PUSH_FRONT)
                                    begin
                                        front_next = (front_reg == '0) ?
                                            cdq_pkg::IDX_W'(cdq_pkg::CAPACITY - 1) :
                                            front_reg - cdq_pkg::IDX_W'(1);
                                        wr.addr    = front_next;
                                    end
                                    else
                                    begin
                                        wr.addr = cdq_pkg::wrap_add(front_reg, occ_reg);
                                    end
                                end
                            end
                            else if (is_empty)
                            begin
                                out_status_next = cdq_pkg::ST_UNDERFLOW;
                            end
                            else
                            begin
                                occ_next = occ_reg - cdq_pkg::CNT_W'(1);
                                if (occ_reg == cdq_pkg::CNT_W'(1))
                                begin
                                    front_next = '0;
                                end
                                else if (action_reg == cdq_pkg::ACT_POP_FRONT)
                                begin
                                    front_next = cdq_pkg::wrap_add(front_reg,
                                                                   cdq_pkg::CNT_W'(1));
                                end
                            end
                        end
                    end

                    cdq_pkg::ACT_TRAVERSE,
                    cdq_pkg::ACT_SEARCH:
                    begin
                        if (is_empty)
                        begin
                            if (slot_free)
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = (action_reg == cdq_pkg::ACT_TRAVERSE) ?
                                                  cdq_pkg::ST_UNDERFLOW :
                                                  cdq_pkg::ST_NOT_FOUND;
                                out_item_next   = '0;
                                out_pos_next    = '0;
                                out_last_next   = 1'b1;
                                state_next      = S_IDLE;
                            end
                        end
                        else
                        begin
                            // Read the front entry first.
                            rd.en      = 1'b1;
                            rd.addr    = front_reg;
                            scan_next  = '0;
                            state_next = S_EVAL;
                        end
                    end

                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_EVAL:
            begin
                if (action_reg == cdq_pkg::ACT_TRAVERSE)
                begin
                    // Emit the entry just read, then fetch the next one.
                    if (slot_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = cdq_pkg::ST_OK;
                        out_item_next   = rd_data;
                        out_pos_next    = '0;
                        out_last_next   = scan_last;
                        if (scan_last)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            scan_next = scan_inc;
                            rd.en     = 1'b1;
                            rd.addr   = cdq_pkg::wrap_add(front_reg, scan_inc);
                        end
                    end
                end
                else if (rd_data == value_reg || scan_last)
                begin
                    // Match found or ring exhausted: one result ends the search.
                    if (slot_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_item_next   = '0;
                        out_last_next   = 1'b1;
                        state_next      = S_IDLE;
                        if (rd_data == value_reg)
                        begin
                            out_status_next = cdq_pkg::ST_OK;
                            out_pos_next    = cdq_pkg::POS_W'(scan_reg);
                        end
                        else
                        begin
                            out_status_next = cdq_pkg::ST_NOT_FOUND;
                            out_pos_next    = '0;
                        end
                    end
                end
                else
                begin
                    scan_next = scan_inc;
                    rd.en     = 1'b1;
                    rd.addr   = cdq_pkg::wrap_add(front_reg, scan_inc);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Request and result payload.
    always_ff @(posedge clk)
    begin
        action_reg     <= action_next;
        value_reg      <= value_next;
        scan_reg       <= scan_next;
        out_status_reg <= out_status_next;
        out_item_reg   <= out_item_next;
        out_pos_reg    <= out_pos_next;
        out_last_reg   <= out_last_next;
    end

    // Ports.
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {cdq_pkg::M_PAD_W'(0), out_pos_reg, out_item_reg};
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

    // Checks.
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= cdq_pkg::CNT_W'(cdq_pkg::CAPACITY))
        else $error("occupancy above capacity");

    a_empty_front: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg == '0 |-> front_reg == '0)
        else $error("empty ring with nonzero front index");

    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EVAL |-> scan_reg < occ_reg)
        else $error("scan beyond stored entries");

    a_no_full_write: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> !is_full && state_reg == S_EXEC)
        else $error("write into a full ring");

    a_result_ends_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_next && !(out_valid_reg && !m_axis_tready) && out_last_next
        |=> state_reg == S_IDLE)
        else $error("final result loaded but request not finished");

endmodule
`default_nettype wire

### dv/tb_circular_deque_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_circular_deque_engine: self-checking bench for the circular deque engine
// A queue-fed driver sends push, pop, traverse, search and unused requests.
// A built-in deque predictor forms the expected results for each accepted
// request. A monitor compares every returned result, field by field, against
// the oldest expected one. The run steps through phases of sender gaps,
// receiver stalls and one long receiver hold-off that backs up the engine.
// ----------------------------------------------------------------------------
module tb_circular_deque_engine;
    import cdq_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 40;
    localparam int POOL_MAX = 32;

    // Operation codes that the engine drops without a result.
    localparam logic [ACT_W-1:0] ACT_UNUSED_6 = 3'd6;
    localparam logic [ACT_W-1:0] ACT_UNUSED_7 = 3'd7;

    typedef struct {
        logic [ACT_W-1:0]  act;
        logic [DATA_W-1:0] value;
    } deque_req_t;

    typedef struct {
        status_t                  status;
        logic signed [DATA_W-1:0] item;
        logic [POS_W-1:0]         position;
        logic                     last;
    } deque_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;   // [31:0] value
    logic [ACT_W-1:0] s_axis_tuser = '0;       // [2:0] action
    logic m_axis_tready = 1'b0;
    logic s_axis_tready;
    logic m_axis_tvalid;
    logic [M_TDATA_W-1:0] m_axis_tdata;        // [31:0] item, [35:32] position
    logic [STAT_W-1:0] m_axis_tuser;           // [1:0] status
    logic m_axis_tlast;

    // Stimulus and expected results.
    deque_req_t pending_reqs[$];
    deque_result_t expected_results[$];
    logic [DATA_W-1:0] value_pool[$];

    // Predictor copy of the deque.
    logic [DATA_W-1:0] shadow_ring[CAPACITY];
    logic [IDX_W-1:0] shadow_front = '0;
    logic [CNT_W-1:0] shadow_count = '0;

    // Idling controls, written at the falling edge only; the hold-off count is kept by the receiver.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic hold_off_armed = 1'b0;
    int hold_count;

    int error_count = 0;
    int cycle_count = 0;

    circular_deque_engine dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock and reset.
    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // One-line mismatch report; every call counts as a failure.
    task automatic report_mismatch(input string msg);
        error_count++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    function automatic void expect_result(input status_t st, input logic [DATA_W-1:0] itm,
                                          input logic [POS_W-1:0] pos, input logic lst);
        deque_result_t r;
        r.status = st;
        r.item = itm;
        r.position = pos;
        r.last = lst;
        expected_results.push_back(r);
    endfunction

    // Deque predictor: applies one accepted request and queues its results.
    function automatic void deque_apply(input logic [ACT_W-1:0] act,
                                        input logic [DATA_W-1:0] val);
        int i;
        logic found;
        found = 1'b0;
        case (act)
            ACT_PUSH_FRONT, ACT_PUSH_BACK:
            begin
                if (shadow_count >= CAPACITY)
                begin
                    expect_result(ST_OVERFLOW, '0, '0, 1'b1);
                end
                else
                begin
                    if (act == ACT_PUSH_FRONT)
                    begin
                        shadow_front = shadow_front - 1'b1;
                        shadow_ring[shadow_front] = val;
                    end
                    else
                    begin
                        shadow_ring[IDX_W'(shadow_front + shadow_count)] = val;
                    end
                    shadow_count = shadow_count + 1'b1;
                    expect_result(ST_OK, '0, '0, 1'b1);
                end
            end
            ACT_POP_FRONT, ACT_POP_BACK:
            begin
                if (shadow_count == 0)
                begin
                    expect_result(ST_UNDERFLOW, '0, '0, 1'b1);
                end
                else
                begin
                    if (act == ACT_POP_FRONT)
                    begin
                        shadow_front = shadow_front + 1'b1;
                    end
                    shadow_count = shadow_count - 1'b1;
                    // An emptied ring restarts at index zero.
                    if (shadow_count == 0)
                    begin
                        shadow_front = '0;
                    end
                    expect_result(ST_OK, '0, '0, 1'b1);
                end
            end
            ACT_TRAVERSE:
            begin
                if (shadow_count == 0)
                begin
                    expect_result(ST_UNDERFLOW, '0, '0, 1'b1);
                end
                for (i = 0; i < shadow_count; i++)
                begin
                    expect_result(ST_OK, shadow_ring[IDX_W'(shadow_front + i)], '0,
                                  (i + 1 == shadow_count));
                end
            end
            ACT_SEARCH:
            begin
                for (i = 0; i < shadow_count && !found; i++)
                begin
                    if (shadow_ring[IDX_W'(shadow_front + i)] == val)
                    begin
                        expect_result(ST_OK, '0, POS_W'(i), 1'b1);
                        found = 1'b1;
                    end
                end
                if (!found)
                begin
                    expect_result(ST_NOT_FOUND, '0, '0, 1'b1);
                end
            end
            default:
            begin
                // Unused codes leave the deque untouched and return nothing.
            end
        endcase
    endfunction

    // Stimulus helpers.
    function automatic void add_req(input logic [ACT_W-1:0] act, input logic [DATA_W-1:0] val);
        deque_req_t r;
        r.act = act;
        r.value = val;
        pending_reqs.push_back(r);
        if (act == ACT_PUSH_FRONT || act == ACT_PUSH_BACK)
        begin
            value_pool.push_back(val);
            if (value_pool.size() > POOL_MAX)
            begin
                void'(value_pool.pop_front());
            end
        end
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 15)
        begin
            case ($urandom_range(4))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'hFFFF_FFFF;
                3: return 32'h0000_0001;
                default: return 32'h0000_0000;
            endcase
        end
        else if (r < 35)
        begin
            return DATA_W'($urandom_range(7));
        end
        return $urandom;
    endfunction

    function automatic logic [DATA_W-1:0] pick_key();
        if (value_pool.size() > 0 && $urandom_range(99) < 65)
        begin
            return value_pool[$urandom_range(value_pool.size() - 1)];
        end
        return pick_value();
    endfunction

    // Random requests in runs: fill bursts, drain bursts and mixed traffic,
    // so that both the full and the empty ring are reached often.
    task automatic queue_random(input int n);
        int made;
        int run_kind;
        int run_len;
        int k;
        int r;
        made = 0;
        while (made < n)
        begin
            run_kind = $urandom_range(3);
            run_len = $urandom_range(6, 18);
            for (k = 0; k < run_len && made < n; k++)
            begin
                r = $urandom_range(99);
                if (run_kind == 0)
                begin
                    add_req((r < 50) ? ACT_PUSH_FRONT : ACT_PUSH_BACK, pick_value());
                end
                else if (run_kind == 1)
                begin
                    if (r < 10)
                    begin
                        add_req(ACT_TRAVERSE, pick_value());
                    end
                    else
                    begin
                        add_req((r < 55) ? ACT_POP_FRONT : ACT_POP_BACK, pick_value());
                    end
                end
                else if (r < 20)
                begin
                    add_req(ACT_PUSH_FRONT, pick_value());
                end
                else if (r < 40)
                begin
                    add_req(ACT_PUSH_BACK, pick_value());
                end
                else if (r < 52)
                begin
                    add_req(ACT_POP_FRONT, pick_value());
                end
                else if (r < 64)
                begin
                    add_req(ACT_POP_BACK, pick_value());
                end
                else if (r < 76)
                begin
                    add_req(ACT_TRAVERSE, pick_value());
                end
                else if (r < 95)
                begin
                    add_req(ACT_SEARCH, pick_key());
                end
                else
                begin
                    // Dropped codes do not count toward the requested total.
                    add_req((r < 97) ? ACT_UNUSED_6 : ACT_UNUSED_7, pick_value());
                    made--;
                end
                made++;
            end
        end
    endtask

    // Waits until every request is sent and every result has come back.
    task automatic drain();
        while (pending_reqs.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Request driver: predicts on acceptance and presents the next request.
    always @(posedge clk or negedge rst_n)
    begin
        deque_req_t nxt;
        logic accepted;
        logic offer;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= '0;
        end
        else
        begin
            accepted = s_axis_tvalid && s_axis_tready;
            if (accepted)
            begin
                deque_apply(s_axis_tuser, s_axis_tdata[DATA_W-1:0]);
            end
            if (!s_axis_tvalid || accepted)
            begin
                offer = (pending_reqs.size() > 0) &&
                        ($urandom_range(99) >= send_idle_pct);
                if (offer)
                begin
                    nxt = pending_reqs.pop_front();
                    s_axis_tdata <= S_TDATA_W'(nxt.value);
                    s_axis_tuser <= nxt.act;
                end
                s_axis_tvalid <= offer;
            end
        end
    end

    // Result receiver, with one long hold-off when armed.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_count <= 0;
        end
        else if (hold_off_armed && hold_count < HOLD_CYCLES)
        begin
            m_axis_tready <= 1'b0;
            hold_count <= hold_count + 1;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Result monitor.
    always @(posedge clk)
    begin
        deque_result_t exp_r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result status=%0d item=%h pos=%0d last=%b",
                                          m_axis_tuser, m_axis_tdata[DATA_W-1:0],
                                          m_axis_tdata[DATA_W +: POS_W], m_axis_tlast));
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (m_axis_tuser != exp_r.status)
                begin
                    report_mismatch($sformatf("status got %0d want %0d",
                                              m_axis_tuser, exp_r.status));
                end
                if (m_axis_tdata[DATA_W-1:0] != exp_r.item)
                begin
                    report_mismatch($sformatf("item got %0d want %0d",
                                              $signed(m_axis_tdata[DATA_W-1:0]), exp_r.item));
                end
                if (m_axis_tdata[DATA_W +: POS_W] != exp_r.position)
                begin
                    report_mismatch($sformatf("position got %0d want %0d",
                                              m_axis_tdata[DATA_W +: POS_W], exp_r.position));
                end
                if (m_axis_tlast != exp_r.last)
                begin
                    report_mismatch($sformatf("last got %b want %b",
                                              m_axis_tlast, exp_r.last));
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        int i;
        for (i = 0; i < CAPACITY; i++)
        begin
            shadow_ring[i] = '0;
        end
        @(posedge rst_n);
        @(negedge clk);

        // Directed: empty ring cases, extremes, hits and misses, unused codes,
        // and popping the only element.
        add_req(ACT_TRAVERSE, 32'h0);
        add_req(ACT_POP_FRONT, 32'h0);
        add_req(ACT_POP_BACK, 32'hFFFF_FFFF);
        add_req(ACT_SEARCH, 32'h0);
        add_req(ACT_PUSH_FRONT, 32'h8000_0000);
        add_req(ACT_PUSH_BACK, 32'h7FFF_FFFF);
        add_req(ACT_PUSH_BACK, 32'hFFFF_FFFF);
        add_req(ACT_PUSH_FRONT, 32'h0);
        add_req(ACT_TRAVERSE, 32'h0);
        add_req(ACT_SEARCH, 32'h7FFF_FFFF);
        add_req(ACT_SEARCH, 32'h0000_3039);
        add_req(ACT_SEARCH, 32'h0);
        add_req(ACT_UNUSED_6, 32'hFFFF_FFFF);
        add_req(ACT_UNUSED_7, 32'h5A5A_A5A5);
        add_req(ACT_POP_FRONT, 32'h0);
        add_req(ACT_POP_BACK, 32'h0);
        add_req(ACT_TRAVERSE, 32'h0);
        add_req(ACT_POP_BACK, 32'h0);
        add_req(ACT_POP_FRONT, 32'h0);
        add_req(ACT_POP_BACK, 32'h0);
        add_req(ACT_PUSH_BACK, 32'h1234_5678);
        add_req(ACT_SEARCH, 32'h1234_5678);
        add_req(ACT_POP_FRONT, 32'h0);
        add_req(ACT_TRAVERSE, 32'h0);
        drain();

        // Random phases with different idling on each side.
        queue_random(45);
        drain();

        send_idle_pct = 60;
        queue_random(45);
        drain();

        send_idle_pct = 0;
        recv_stall_pct = 60;
        queue_random(45);
        drain();

        send_idle_pct = 9;
        recv_stall_pct = 9;
        queue_random(45);
        drain();

        // Long receiver hold-off while requests keep coming.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_armed = 1'b1;
        queue_random(30);
        drain();

        repeat (SETTLE_CYCLES) @(negedge clk);
        if (error_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
